// ----- rtl/bfaq_pkg.sv -----
// Shared constants and interface types of the Bloom filter add/query block.
`default_nettype none

package bfaq_pkg;

    // Bitmap geometry: 65536 bits kept as 8192 rows of one byte.
    localparam int unsigned MAP_BITS = 65536;
    localparam int unsigned MAP_ROWS = MAP_BITS / 8;
    localparam int unsigned ROW_AW   = $clog2(MAP_ROWS);
    localparam int unsigned MOD_W    = $clog2(MAP_BITS) + 1;

    // Number of probes per key.
    localparam int unsigned HASH_COUNT = 10;

    // Primes of the two base hashes.
    localparam logic [21:0] PRIME_A = 22'd4189793;
    localparam logic [21:0] PRIME_B = 22'd3296731;

    // Operation codes carried on the input tuser.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Access request from the sequencer to the bitmap.
    typedef struct packed {
        logic              set_en;
        logic              rd_en;
        logic [ROW_AW-1:0] addr;
        logic [2:0]        bitpos;
    } t_map_req;

    // Bitmap status and registered read data.
    typedef struct packed {
        logic       busy;
        logic [7:0] rd_data;
    } t_map_rsp;

endpackage

`default_nettype wire

// ----- rtl/bfaq_bitmap.sv -----
// Byte-wide bitmap memory with a bit-set write port, a read port and a clearing pass.
`default_nettype none

module bfaq_bitmap
    import bfaq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_map_req i_req,
    output t_map_rsp      o_rsp
);

    logic [7:0]        r_mem [MAP_ROWS];
    logic [7:0]        r_rd_data;
    logic              r_clr_busy;
    logic [ROW_AW-1:0] r_clr_addr;

    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(MAP_ROWS - 1);

    // Clearing pass after reset, one row per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ROW_LAST) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Memory array: row clear or single bit set, registered read.
    // Bit b of the filter sits at position 7 - (b mod 8) of its row.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.set_en) begin
            r_mem[i_req.addr][~i_req.bitpos] <= 1'b1;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rsp.busy    = r_clr_busy;
    assign o_rsp.rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/bloom_filter_add_query.sv -----
// Top level of the Bloom filter: command sequencer, shared residue unit and probe walk.
//
// Input stream: tuser is the command (0 adds the key, 1 queries it), tdata bits 62:0
// hold the key. Output stream: tdata bit 0 is found, one result per input transfer;
// an add always returns 0. The configuration channel writes bits_in_use, which is
// rounded down to a multiple of eight, raised to 8 if zero and capped at 65536.
//
// An item is taken only once the previous one has finished. The work is done by one pair
// of shared compare-subtract lanes: the key is reduced by both primes at three bits a
// cycle, those residues, each plus one, are reduced by the bit count, then the probes
// are walked, one bitmap access each, and the sequencer finishes through its drain and
// done states.
//
// After reset a clearing pass zeroes the bitmap, one byte row per cycle, over all 8192
// rows; no item is taken until it ends, configuration writes are taken throughout.
// A result waits in the output register while the receiver stalls; the next item is
// still taken and worked on, and it finishes only once that register is free.
`default_nettype none

module bloom_filter_add_query
    import bfaq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [62:0] key, [63] zero
    input  wire logic        i_s_axis_tuser,   // [0] command
    // Output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [0] found, [7:1] zero
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data        // [16:0] bits_in_use
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_MODM,
        S_PROBE,
        S_DRAIN,
        S_DONE
    } t_state;

    localparam int unsigned KEY_STEPS = 21;
    localparam int unsigned MOD_STEPS = 8;
    localparam int unsigned CNT_W     = 5;

    localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MAP_BITS);
    localparam logic [MOD_W-1:0] MOD_MIN = MOD_W'(8);

    // Three restoring steps of r = (2r + bit) mod p, with r < p.
    function automatic logic [21:0] red_step3(input logic [21:0] r, input logic [2:0] bits,
                                              input logic [21:0] p);
        logic [22:0] t;
        logic [21:0] acc;
        acc = r;
        for (int k = 2; k >= 0; k--) begin
            t = {acc, bits[k]};
            if (t >= {1'b0, p}) begin
                t = t - {1'b0, p};
            end
            acc = t[21:0];
        end
        return acc;
    endfunction

    // Sum of two residues below m, reduced once.
    function automatic logic [MOD_W-1:0] mod_add(input logic [MOD_W-1:0] a,
                                                 input logic [MOD_W-1:0] b,
                                                 input logic [MOD_W-1:0] m);
        logic [MOD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MOD_W-1:0];
    endfunction

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [MOD_W-1:0]   r_mod;
    logic               r_cmd;
    logic [62:0]        r_key;
    logic [21:0]        r_ra;
    logic [21:0]        r_rb;
    logic [23:0]        r_xa;
    logic [23:0]        r_xb;
    logic [MOD_W-1:0]   r_h;
    logic [MOD_W-1:0]   r_d;
    logic               r_all;
    logic               r_chk_vld;
    logic [2:0]         r_chk_pos;
    logic               r_out_vld;
    logic               r_found;

    logic [21:0]        n_ra;
    logic [21:0]        n_rb;
    logic [2:0]         lane_bits_a;
    logic [2:0]         lane_bits_b;
    logic [21:0]        lane_p_a;
    logic [21:0]        lane_p_b;
    logic [MOD_W-1:0]   n_h;
    logic [MOD_W-1:0]   n_d;
    logic [MOD_W-1:0]   cfg_mod;
    logic               in_xfer;
    logic               chk_fail;
    logic               out_free;
    t_map_req           map_req;
    t_map_rsp           map_rsp;

    // Effective modulus from a bits_in_use write.
    always_comb begin
        cfg_mod = {i_cfg_data[16:3], 3'b000};
        if (cfg_mod == '0) begin
            cfg_mod = MOD_MIN;
        end else if (cfg_mod > MOD_MAX) begin
            cfg_mod = MOD_MAX;
        end
    end

    // Shared residue lanes: key by the primes, then the offsets by the bit count.
    always_comb begin
        if (r_state == S_KEY) begin
            lane_bits_a = r_key[62:60];
            lane_bits_b = r_key[62:60];
            lane_p_a    = PRIME_A;
            lane_p_b    = PRIME_B;
        end else begin
            lane_bits_a = r_xa[23:21];
            lane_bits_b = r_xb[23:21];
            lane_p_a    = 22'(r_mod);
            lane_p_b    = 22'(r_mod);
        end
        n_ra = red_step3(r_ra, lane_bits_a, lane_p_a);
        n_rb = red_step3(r_rb, lane_bits_b, lane_p_b);
    end

    // Probe walk: h advances by d, and d by two, both modulo the bit count.
    assign n_h = mod_add(r_h, r_d, r_mod);
    assign n_d = mod_add(r_d, MOD_W'(2), r_mod);

    // Bitmap access for the current probe.
    always_comb begin
        map_req.set_en = (r_state == S_PROBE) && (r_cmd == CMD_ADD);
        map_req.rd_en  = (r_state == S_PROBE) && (r_cmd == CMD_QUERY);
        map_req.addr   = r_h[ROW_AW+2:3];
        map_req.bitpos = r_h[2:0];
    end

    bfaq_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE) && !map_rsp.busy;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign chk_fail        = r_chk_vld && !map_rsp.rd_data[~r_chk_pos];
    assign out_free        = !r_out_vld || i_m_axis_tready;

    // Sequencer and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_mod     <= MOD_MAX;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_chk_vld <= map_req.rd_en;
            r_chk_pos <= r_h[2:0];
            if (chk_fail) begin
                r_all <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_mod <= cfg_mod;
            end
            if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_s_axis_tuser;
                        r_key   <= i_s_axis_tdata[62:0];
                        r_ra    <= '0;
                        r_rb    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_key <= {r_key[59:0], 3'b000};
                    r_ra  <= n_ra;
                    r_rb  <= n_rb;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(KEY_STEPS - 1)) begin
                        r_xa    <= {1'b0, 23'(n_ra) + 23'd1};
                        r_xb    <= {1'b0, 23'(n_rb) + 23'd1};
                        r_ra    <= '0;
                        r_rb    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MODM;
                    end
                end
                S_MODM: begin
                    r_xa  <= {r_xa[20:0], 3'b000};
                    r_xb  <= {r_xb[20:0], 3'b000};
                    r_ra  <= n_ra;
                    r_rb  <= n_rb;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                        r_h     <= n_ra[MOD_W-1:0];
                        r_d     <= n_rb[MOD_W-1:0];
                        r_all   <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_h   <= n_h;
                    r_d   <= n_d;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(HASH_COUNT - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_found   <= (r_cmd == CMD_QUERY) && r_all;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'b0000000, r_found};
    assign o_cfg_ready     = 1'b1;

    // No item is taken while the bitmap is still being cleared.
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(map_rsp.busy && in_xfer))
        else $error("input transfer during bitmap clearing pass");

    // Every probe lands inside the configured bit count.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_h < r_mod) && (r_d < r_mod))
        else $error("probe index outside the bit count");

    // A probe either sets or reads, never both.
    a_req_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(map_req.set_en && map_req.rd_en))
        else $error("bitmap set and read in one cycle");

    // A new result appears only as the sequencer leaves its finishing state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the finishing state");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the Bloom filter add/query block with its own filter predictor.
`default_nettype none

module testbench;
    import bfaq_pkg::*;

    localparam int unsigned     CYCLE_LIMIT     = 1_200_000;
    localparam int unsigned     DRAIN_CYCLES    = 60;
    localparam int unsigned     ITEMS_PER_PHASE = 185;
    localparam longint unsigned HASH_PRIME_A    = 64'd4189793;
    localparam longint unsigned HASH_PRIME_B    = 64'd3296731;
    localparam logic [62:0]     KEY_MAX         = {63{1'b1}};

    // Clock, reset and block ports.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata  = '0;     // [62:0] key, [63] zero
    logic        i_s_axis_tuser  = 1'b0;   // [0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;           // [0] found, [7:1] zero
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data      = '0;     // [16:0] bits_in_use

    // Predicted filter contents and the current bit count register.
    bit          filter_bits [MAP_BITS];
    logic [16:0] bits_in_use = 17'd65536;

    // Found flags still owed by the block, and keys added in the current phase.
    logic        pending_found [$];
    logic [62:0] added_keys [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    always #5 i_clk = ~i_clk;

    bloom_filter_add_query u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // The probe modulus: rounded down to whole bytes, never zero, never past the map.
    function automatic int unsigned probe_modulus();
        int unsigned m;
        m = 32'(bits_in_use) & ~32'd7;
        if (m == 0) begin
            m = 8;
        end
        if (m > MAP_BITS) begin
            m = MAP_BITS;
        end
        return m;
    endfunction

    // Walks the probes of one key: an add sets them, a query reports whether all are set.
    function automatic logic filter_apply(input logic cmd, input logic [62:0] key);
        longint unsigned k;
        longint unsigned res_a;
        longint unsigned res_b;
        longint unsigned h;
        longint unsigned p;
        int unsigned     m;
        int unsigned     bit_idx;
        logic            all_set;
        k       = {1'b0, key};
        res_a   = k % HASH_PRIME_A;
        res_b   = k % HASH_PRIME_B;
        m       = probe_modulus();
        all_set = 1'b1;
        for (p = 0; p < HASH_COUNT; p++) begin
            h       = res_a + p * res_b + 64'd1 + p * p;
            bit_idx = 32'(h % longint'(m));
            if (cmd == CMD_ADD) begin
                filter_bits[bit_idx] = 1'b1;
            end else if (!filter_bits[bit_idx]) begin
                all_set = 1'b0;
            end
        end
        return (cmd == CMD_QUERY) && all_set;
    endfunction

    // Idle length: mostly a few cycles, now and then a long pause.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    // Keys near zero, near the top, at or just above multiples of both primes, or anywhere.
    function automatic logic [62:0] random_key();
        logic [62:0] key;
        case ($urandom_range(0, 9))
            0: begin
                key = 63'($urandom_range(0, 1000));
            end
            1: begin
                key = KEY_MAX - 63'($urandom_range(0, 1000));
            end
            2: begin
                key = 63'(HASH_PRIME_A * HASH_PRIME_B * longint'($urandom_range(0, 100000))
                          + longint'($urandom_range(0, 2)));
            end
            default: begin
                key = 63'({$urandom, $urandom});
            end
        endcase
        return key;
    endfunction

    // Offers one item, waits for its transfer and records the found flag it should return.
    task automatic send_item(input logic cmd, input logic [62:0] key);
        int unsigned gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 3) == 0) begin
            gap = gap_len();
        end
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {1'b0, key};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_found.push_back(filter_apply(cmd, key));
        if (cmd == CMD_ADD) begin
            added_keys.push_back(key);
        end
    endtask

    // Stops offering items and lets every owed result come back.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_found.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes bits_in_use once the block is idle; the bitmap keeps its contents.
    task automatic write_bits_in_use(input logic [16:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bits_in_use = value;
        added_keys.delete();
    endtask

    // Reset bit count: the extreme keys, add then query, and keys on the primes.
    task automatic test_default_bit_count();
        send_item(CMD_QUERY, '0);
        send_item(CMD_ADD, '0);
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, KEY_MAX);
        send_item(CMD_ADD, KEY_MAX);
        send_item(CMD_QUERY, KEY_MAX);
        send_item(CMD_ADD, 63'(HASH_PRIME_A));
        send_item(CMD_QUERY, 63'(HASH_PRIME_A));
        send_item(CMD_QUERY, 63'(HASH_PRIME_B));
        send_item(CMD_QUERY, 63'(HASH_PRIME_A * HASH_PRIME_B));
    endtask

    // Bit count rounding, the floor of eight, saturation, and bits kept across writes.
    task automatic test_bit_count_limits();
        write_bits_in_use(17'h1FFFF);
        send_item(CMD_QUERY, KEY_MAX);
        write_bits_in_use(17'd12);
        send_item(CMD_ADD, 63'd5);
        send_item(CMD_QUERY, 63'd123456789);
        send_item(CMD_QUERY, KEY_MAX);
        write_bits_in_use(17'd3);
        send_item(CMD_QUERY, random_key());
        write_bits_in_use(17'd0);
        send_item(CMD_QUERY, {32'h2AAAAAAA, 31'h55555555});
        write_bits_in_use(17'd8);
        send_item(CMD_QUERY, '0);
        write_bits_in_use(17'd65536);
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, 63'(HASH_PRIME_A));
    endtask

    // Random adds and queries over several bit counts; most queries look up added keys.
    task automatic test_random_traffic();
        logic [16:0] phase_bits [8];
        int unsigned r;
        phase_bits = '{17'd65536, 17'd8, 17'd1001, 17'd65535,
                       17'd70000, 17'd0, 17'd2048, 17'd65536};
        phase_bits[5] = 17'($urandom_range(0, 131071));
        foreach (phase_bits[ph]) begin
            write_bits_in_use(phase_bits[ph]);
            tx_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
            rx_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 9);
                if (r < 4 || added_keys.size() == 0) begin
                    send_item(CMD_ADD, random_key());
                end else if (r < 8) begin
                    send_item(CMD_QUERY, added_keys[$urandom_range(0, added_keys.size() - 1)]);
                end else begin
                    send_item(CMD_QUERY, random_key());
                end
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
    endtask

    // Result side back-pressure.
    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 4) == 0) begin
                    stall = gap_len();
                end
            end
        end
    end

    // Compares each result transfer with the oldest owed found flag.
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_found.size() == 0) begin
                $error("found: expected no result, actual %0d", o_m_axis_tdata[0]);
                error_count++;
            end else begin
                want = pending_found.pop_front();
                if (o_m_axis_tdata[0] !== want) begin
                    $error("found: expected %0d, actual %0d", want, o_m_axis_tdata[0]);
                    error_count++;
                end
            end
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Test sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_bit_count();
        test_bit_count_limits();
        test_random_traffic();
        wait_idle();
        if (pending_found.size() == 0 && error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- bloom_filter_add_query.f -----
rtl/bfaq_pkg.sv
rtl/bfaq_bitmap.sv
rtl/bloom_filter_add_query.sv
sim/testbench.sv
